// File: design/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the software timer slot table.
// No dependencies; used by stt_cell and software_timer_slot_table_core.
package stt_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int POS_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_START_ONE = 3'd1,
    KIND_START_PER = 3'd2,
    KIND_CANCEL    = 3'd3,
    KIND_RESTART   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_EMPTY    = 2'd0,
    MODE_ONCE     = 2'd1,
    MODE_PERIODIC = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    STAT_IDLE    = 3'd0,
    STAT_FIRED   = 3'd1,
    STAT_STARTED = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_DONE    = 3'd4,
    STAT_BAD     = 3'd5
  } status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now;
    logic [31:0] duration;
    logic        match;
  } cmd_t;

  // Events raised by the cell that holds the scan token.
  typedef struct packed {
    logic fire;
    logic per;
    logic take;
    logic hit;
  } evt_t;

endpackage

// File: design/stt_cell.sv
`timescale 1ns / 1ps
// One timer slot: mode, start time and duration, plus the scan token stage.
// Depends on stt_pkg.
module stt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  stt_pkg::cmd_t cmd,
  input  logic          tok_in,
  input  logic          found_in,
  output logic          tok_out,
  output logic          found_out,
  output stt_pkg::evt_t evt
);
  import stt_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] length_r, length_nxt;
  logic        tok_r;
  logic        found_r;

  logic [31:0] expiry;
  logic        expired;
  logic        is_start;
  logic        is_slot_op;
  logic        fire, take, hit;

  always_comb begin
    expiry     = start_r + length_r;
    expired    = cmd.now > expiry;
    is_start   = (cmd.kind == KIND_START_ONE) || (cmd.kind == KIND_START_PER);
    is_slot_op = (cmd.kind == KIND_CANCEL) || (cmd.kind == KIND_RESTART);
    fire = tok_in && (cmd.kind == KIND_TICK) && (mode_r != MODE_EMPTY) && expired;
    take = tok_in && is_start && !found_in && (mode_r == MODE_EMPTY);
    hit  = tok_in && is_slot_op && cmd.match && (mode_r != MODE_EMPTY);

    evt.fire = fire;
    evt.per  = tok_in && (mode_r == MODE_PERIODIC);
    evt.take = take;
    evt.hit  = hit;
  end

  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    length_nxt = length_r;
    priority if (fire) begin
      // one-shot drops out, periodic rearms at the current time
      if (mode_r == MODE_ONCE) mode_nxt = MODE_EMPTY;
      else start_nxt = cmd.now;
    end else if (take) begin
      mode_nxt   = (cmd.kind == KIND_START_ONE) ? MODE_ONCE : MODE_PERIODIC;
      start_nxt  = cmd.now;
      length_nxt = cmd.duration;
    end else if (hit) begin
      if (cmd.kind == KIND_CANCEL) mode_nxt = MODE_EMPTY;
      else start_nxt = cmd.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_EMPTY;
      tok_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      tok_r   <= tok_in;
      found_r <= found_in | take;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    length_r <= length_nxt;
  end

  assign tok_out   = tok_r;
  assign found_out = found_r;

endmodule

// File: design/software_timer_slot_table_core.sv
`timescale 1ns / 1ps
// Top level of the timer slot table: request control, time counter, result
// sequencing and the chain of slot cells. Depends on stt_pkg and stt_cell.
//
//  channel   handshake             payload
//  request   start / busy          in_kind, in_slot, in_duration
//  result    out_strobe (1 cycle)  out_status, out_slot_index,
//                                  out_was_periodic, out_last
//
// A request walks a scan token down the cell chain one slot a cycle, then S_DONE
// builds the final result.
// busy is high from the cycle after acceptance until the final result is
// registered; the next request can be taken while that result is shown.
// Each fired result of a tick goes out when the next slot fires, or at the end.
// Synchronous reset empties every slot and clears the time counter.
// The receiver cannot stall; every result is shown for exactly one cycle.
module software_timer_slot_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [5:0]  in_slot,
  input  logic [31:0] in_duration,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_index,
  output logic        out_was_periodic,
  output logic        out_last
);
  import stt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       kind_r;
  logic [5:0]       slot_r;
  logic [31:0]      dur_r;
  logic [31:0]      now_r, now_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             inj_r;
  logic             pend_v_r, pend_v_nxt;
  logic [POS_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             pend_per_r, pend_per_nxt;
  logic             hit_r, hit_nxt;
  logic [POS_W-1:0] hit_idx_r, hit_idx_nxt;

  logic             strobe_r, strobe_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [5:0]       idx_r, idx_nxt;
  logic             per_r, per_nxt;
  logic             last_r, last_nxt;

  logic             accept;
  cmd_t             cmd;
  logic [SLOT_COUNT:0] tok;
  logic [SLOT_COUNT:0] found;
  evt_t             evts [SLOT_COUNT];
  evt_t             evt_any;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    cmd.kind     = kind_r;
    cmd.now      = now_r;
    cmd.duration = dur_r;
    cmd.match    = (6'(pos_r) == slot_r);
  end

  assign tok[0]   = inj_r;
  assign found[0] = 1'b0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    stt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .tok_in   (tok[g]),
      .found_in (found[g]),
      .tok_out  (tok[g+1]),
      .found_out(found[g+1]),
      .evt      (evts[g])
    );
  end

  // only the token holder raises events, so an OR picks them up
  always_comb begin
    evt_any = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      evt_any = evt_any | evts[i];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    pos_nxt      = pos_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_per_nxt = pend_per_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    idx_nxt      = idx_r;
    per_nxt      = per_r;
    last_nxt     = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_SCAN;
          pos_nxt    = '0;
          pend_v_nxt = 1'b0;
          hit_nxt    = 1'b0;
          // advance time before the tick scan compares
          if (kind_t'(in_kind) == KIND_TICK) now_nxt = now_r + 32'd1;
        end
      end
      S_SCAN: begin
        if (evt_any.fire) begin
          // release the previous fired slot, it is not the last one
          if (pend_v_r) begin
            strobe_nxt = 1'b1;
            status_nxt = STAT_FIRED;
            idx_nxt    = 6'(pend_idx_r);
            per_nxt    = pend_per_r;
            last_nxt   = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = pos_r;
          pend_per_nxt = evt_any.per;
        end
        if (evt_any.take || evt_any.hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pos_r;
        end
        if (pos_r == POS_W'(SLOT_COUNT - 1)) state_nxt = S_DONE;
        else pos_nxt = pos_r + 1'b1;
      end
      S_DONE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        per_nxt    = 1'b0;
        idx_nxt    = '0;
        unique case (kind_r)
          KIND_TICK: begin
            if (pend_v_r) begin
              status_nxt = STAT_FIRED;
              idx_nxt    = 6'(pend_idx_r);
              per_nxt    = pend_per_r;
            end else begin
              status_nxt = STAT_IDLE;
            end
          end
          KIND_START_ONE, KIND_START_PER: begin
            if (hit_r) begin
              status_nxt = STAT_STARTED;
              idx_nxt    = 6'(hit_idx_r);
            end else begin
              status_nxt = STAT_FULL;
            end
          end
          KIND_CANCEL, KIND_RESTART: begin
            status_nxt = hit_r ? STAT_DONE : STAT_BAD;
          end
          default: status_nxt = STAT_BAD;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      now_r    <= '0;
      inj_r    <= 1'b0;
      strobe_r <= 1'b0;
      pend_v_r <= 1'b0;
      hit_r    <= 1'b0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      inj_r    <= accept;
      strobe_r <= strobe_nxt;
      pend_v_r <= pend_v_nxt;
      hit_r    <= hit_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      slot_r <= in_slot;
      dur_r  <= in_duration;
    end
    pend_idx_r <= pend_idx_nxt;
    pend_per_r <= pend_per_nxt;
    hit_idx_r  <= hit_idx_nxt;
    status_r   <= status_nxt;
    idx_r      <= idx_nxt;
    per_r      <= per_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_slot_index   = idx_r;
  assign out_was_periodic = per_r;
  assign out_last         = last_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one scan token in the cell chain");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (tok[SLOT_COUNT:1] != '0) |-> (state_r == S_SCAN) || (state_r == S_DONE))
    else $error("scan token outside a scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_TICK)) |=> (now_r == $past(now_r) + 32'd1))
    else $error("tick did not advance the time counter");

  a_strobe_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(state_r) != S_IDLE)
    else $error("result strobe without a request in progress");

  a_found_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (found[SLOT_COUNT] ==
      (hit_r && ((kind_r == KIND_START_ONE) || (kind_r == KIND_START_PER)))))
    else $error("allocation flag at the chain end disagrees with the scan");

endmodule

// File: dv/software_timer_slot_table_core_test.sv
`timescale 1ns / 1ps
// Testbench for software_timer_slot_table_core: directed table, then random requests,
// every report checked against a bench-tracked slot table or its typed script row.
// Depends on stt_pkg and the design sources; needs no files or arguments.
module software_timer_slot_table_core_test;
  import stt_pkg::*;

  localparam logic [2:0] KIND_SPARE = 3'd5;
  localparam logic [2:0] KIND_TOP   = 3'd7;
  localparam int         SCRIPT_LEN = 25;
  localparam int         RANDOM_REQUESTS = 85;
  localparam int         DRAIN_CYCLES = 2 * (SLOT_COUNT + 2);

  typedef struct packed {
    status_t    status;
    logic [5:0] slot_index;
    logic       was_periodic;
    logic       last;
  } report_t;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  slot;
    logic [31:0] duration;
    bit          typed;
    status_t     status;
    logic [5:0]  slot_index;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [5:0]  in_slot;
  logic [31:0] in_duration;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [5:0]  out_slot_index;
  logic        out_was_periodic;
  logic        out_last;

  // Slot table as the bench sees it
  mode_t       slot_kind [SLOT_COUNT];
  logic [31:0] slot_since[SLOT_COUNT];
  logic [31:0] slot_span [SLOT_COUNT];
  logic [31:0] now_ticks;

  report_t     request_reports[$];
  report_t     expected_reports[$];
  script_row_t script[SCRIPT_LEN];
  int          mismatch_count;

  software_timer_slot_table_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_duration      (in_duration),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_was_periodic (out_was_periodic),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one request to the tracked table; leave its reports in request_reports.
  task automatic track_request(input logic [2:0] kind, input logic [5:0] slot,
                               input logic [31:0] duration);
    report_t     rep;
    logic [31:0] expiry;
    int          idx;
    bit          placed;
    request_reports.delete();
    rep = '{STAT_BAD, 6'd0, 1'b0, 1'b1};
    case (kind)
      KIND_TICK: begin
        now_ticks = now_ticks + 32'd1;
        for (idx = 0; idx < SLOT_COUNT; idx++) begin
          expiry = slot_since[idx] + slot_span[idx];
          if (slot_kind[idx] != MODE_EMPTY && now_ticks > expiry) begin
            request_reports.push_back('{STAT_FIRED, 6'(idx),
                                       slot_kind[idx] == MODE_PERIODIC, 1'b0});
            if (slot_kind[idx] == MODE_ONCE) slot_kind[idx] = MODE_EMPTY;
            else slot_since[idx] = now_ticks;
          end
        end
        if (request_reports.size() == 0) begin
          rep = '{STAT_IDLE, 6'd0, 1'b0, 1'b1};
        end else begin
          rep = request_reports.pop_back();
          rep.last = 1'b1;
        end
      end
      KIND_START_ONE, KIND_START_PER: begin
        placed = 1'b0;
        rep = '{STAT_FULL, 6'd0, 1'b0, 1'b1};
        for (idx = 0; idx < SLOT_COUNT; idx++) begin
          if (!placed && slot_kind[idx] == MODE_EMPTY) begin
            placed = 1'b1;
            slot_kind[idx]  = (kind == KIND_START_ONE) ? MODE_ONCE : MODE_PERIODIC;
            slot_since[idx] = now_ticks;
            slot_span[idx]  = duration;
            rep = '{STAT_STARTED, 6'(idx), 1'b0, 1'b1};
          end
        end
      end
      KIND_CANCEL, KIND_RESTART: begin
        if (slot < SLOT_COUNT && slot_kind[slot] != MODE_EMPTY) begin
          if (kind == KIND_CANCEL) slot_kind[slot] = MODE_EMPTY;
          else slot_since[slot] = now_ticks;
          rep = '{STAT_DONE, 6'd0, 1'b0, 1'b1};
        end
      end
      default: ;
    endcase
    request_reports.push_back(rep);
  endtask

  // Present one request and hold it until the block takes it.
  task automatic issue_request(input logic [2:0] kind, input logic [5:0] slot,
                               input logic [31:0] duration, input bit typed,
                               input report_t typed_report);
    @(negedge clk);
    start       <= 1'b1;
    in_kind     <= kind;
    in_slot     <= slot;
    in_duration <= duration;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_request(kind, slot, duration);
    if (typed) begin
      request_reports.delete();
      request_reports.push_back(typed_report);
    end
    foreach (request_reports[k]) expected_reports.push_back(request_reports[k]);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_strobe) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report status=%0d slot=%0d periodic=%0d last=%0d",
                 $time, out_status, out_slot_index, out_was_periodic, out_last);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        if (want.status != out_status || want.slot_index != out_slot_index ||
            want.was_periodic != out_was_periodic || want.last != out_last) begin
          $display("%0t: expected status=%0d slot=%0d periodic=%0d last=%0d, got %0d %0d %0d %0d",
                   $time, want.status, want.slot_index, want.was_periodic, want.last,
                   out_status, out_slot_index, out_was_periodic, out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [2:0]  kind;
    logic [5:0]  slot;
    logic [31:0] duration;
    int          pick;
    int          burst;
    int          sent;
    report_t     typed_report;

    start          = 1'b0;
    in_kind        = KIND_TICK;
    in_slot        = 6'd0;
    in_duration    = 32'd0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    now_ticks      = 32'd0;
    foreach (slot_kind[k]) begin
      slot_kind[k]  = MODE_EMPTY;
      slot_since[k] = 32'd0;
      slot_span[k]  = 32'd0;
    end

    script[0]  = '{KIND_TICK,      6'd0,  32'd0,          1'b1, STAT_IDLE,    6'd0};
    script[1]  = '{KIND_CANCEL,    6'd0,  32'hFFFFFFFF,   1'b1, STAT_BAD,     6'd0};
    script[2]  = '{KIND_RESTART,   6'd63, 32'd0,          1'b1, STAT_BAD,     6'd0};
    script[3]  = '{KIND_SPARE,     6'd0,  32'd0,          1'b1, STAT_BAD,     6'd0};
    script[4]  = '{KIND_TOP,       6'd63, 32'hFFFFFFFF,   1'b1, STAT_BAD,     6'd0};
    script[5]  = '{KIND_START_ONE, 6'd0,  32'd0,          1'b1, STAT_STARTED, 6'd0};
    script[6]  = '{KIND_START_PER, 6'd0,  32'd0,          1'b1, STAT_STARTED, 6'd1};
    // expiry sum wraps to zero, so this one fires on the next tick
    script[7]  = '{KIND_START_ONE, 6'd0,  32'hFFFFFFFF,   1'b1, STAT_STARTED, 6'd2};
    script[8]  = '{KIND_START_PER, 6'd0,  32'd2,          1'b1, STAT_STARTED, 6'd3};
    script[9]  = '{KIND_TICK,      6'd0,  32'd0,          1'b0, STAT_IDLE,    6'd0};
    script[10] = '{KIND_RESTART,   6'd3,  32'd0,          1'b1, STAT_DONE,    6'd0};
    script[11] = '{KIND_CANCEL,    6'd1,  32'd0,          1'b1, STAT_DONE,    6'd0};
    script[12] = '{KIND_CANCEL,    6'd1,  32'd0,          1'b1, STAT_BAD,     6'd0};
    script[13] = '{KIND_RESTART,   6'(SLOT_COUNT), 32'd0, 1'b1, STAT_BAD,     6'd0};
    for (int r = 14; r < 21; r++)
      script[r] = '{(r % 2) ? KIND_START_PER : KIND_START_ONE, 6'd0, 32'(r % 3),
                    1'b0, STAT_IDLE, 6'd0};
    script[21] = '{KIND_START_ONE, 6'd0,  32'd0,          1'b1, STAT_FULL,    6'd0};
    script[22] = '{KIND_START_PER, 6'd0,  32'd5,          1'b1, STAT_FULL,    6'd0};
    script[23] = '{KIND_TICK,      6'd0,  32'd0,          1'b0, STAT_IDLE,    6'd0};
    script[24] = '{KIND_TICK,      6'd0,  32'd0,          1'b0, STAT_IDLE,    6'd0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      typed_report = '{script[r].status, script[r].slot_index, 1'b0, 1'b1};
      issue_request(script[r].kind, script[r].slot, script[r].duration,
                    script[r].typed, typed_report);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 12));
    end

    // Random part: bursts of requests with random gaps between them.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && sent < RANDOM_REQUESTS; b++) begin
        pick     = $urandom_range(0, 99);
        slot     = 6'($urandom_range(0, 63));
        duration = $urandom();
        if (pick < 40) begin
          kind = KIND_TICK;
        end else if (pick < 62) begin
          kind = $urandom_range(0, 1) ? KIND_START_PER : KIND_START_ONE;
          pick = $urandom_range(0, 99);
          // mostly short spans so slots fire; some that wrap the expiry sum
          if (pick < 70) duration = $urandom_range(0, 6);
          else if (pick < 85) duration = 32'hFFFFFFFF - $urandom_range(0, 4);
        end else if (pick < 92) begin
          kind = $urandom_range(0, 1) ? KIND_RESTART : KIND_CANCEL;
          if ($urandom_range(0, 4) != 0) slot = 6'($urandom_range(0, SLOT_COUNT - 1));
        end else begin
          kind = 3'($urandom_range(KIND_SPARE, KIND_TOP));
        end
        issue_request(kind, slot, duration, 1'b0, typed_report);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 14));
    end
    hold_off(1);

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/stt_pkg.sv
design/stt_cell.sv
design/software_timer_slot_table_core.sv
dv/software_timer_slot_table_core_test.sv
